>>> sv/tccb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_pkg
// Shared constants, codes and CORDIC tables of the compass bearing block.
// ----------------------------------------------------------------------------
package tccb_pkg;

	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int CORDIC_ITERATIONS_MAX = 24;

	// angle accumulator: 2^32 units per turn
	localparam int ZW = 34;
	localparam logic signed [ZW-1:0] ANG_QUARTER = 34'sd1073741824;
	localparam logic signed [ZW-1:0] INV_GAIN_Q30 = 34'sd652032874;

	localparam logic signed [ZW-1:0] ATAN_TAB [0:CORDIC_ITERATIONS_MAX-1] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
		34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
		34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
		34'sd652, 34'sd326, 34'sd163, 34'sd81
	};

	localparam int CFG_DW = 32;
	localparam int CFG_AW = 2;

	typedef enum logic [CFG_AW-1:0] {
		CFG_MAG_MIN   = 2'd0,
		CFG_MAG_MAX   = 2'd1,
		CFG_TILT_LIM  = 2'd2,
		CFG_FIELD_EPS = 2'd3
	} cfg_idx_t;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_GRAVITY = 2'd1;
	localparam status_t ST_TILT    = 2'd2;
	localparam status_t ST_FIELD   = 2'd3;

endpackage

>>> sv/tccb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_if
// Valid/ready channels for sensor samples and bearing results.
// ----------------------------------------------------------------------------
interface tccb_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] field_x;
	logic signed [15:0] field_y;
	logic signed [15:0] field_z;

	modport source (output valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
		output ready);
endinterface

interface tccb_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] heading;
	logic [1:0]         status;

	modport source (output valid, heading, status, input ready);
	modport sink (input valid, heading, status, output ready);
endinterface

>>> sv/tccb_vec_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_vec_cordic
// Pipelined vectoring CORDIC: angle of (x, y), one iteration per stage.
// ----------------------------------------------------------------------------
module tccb_vec_cordic #(
	parameter int W = 36,
	parameter int N = tccb_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [W-1:0]           x_in,
	input  logic signed [W-1:0]           y_in,
	output logic signed [tccb_pkg::ZW-1:0] z_out
);

	logic signed [W-1:0]            x_q [0:N];
	logic signed [W-1:0]            y_q [0:N];
	logic signed [tccb_pkg::ZW-1:0] z_q [0:N];
	logic                           zero_q [0:N];

	logic signed [W-1:0]            pre_x;
	logic signed [W-1:0]            pre_y;
	logic signed [tccb_pkg::ZW-1:0] pre_z;

	// rotate the left half plane into the right one
	always_comb begin
		pre_x = x_in;
		pre_y = y_in;
		pre_z = '0;
		if (x_in[W-1]) begin
			if (!y_in[W-1]) begin
				pre_x = y_in;
				pre_y = -x_in;
				pre_z = tccb_pkg::ANG_QUARTER;
			end else begin
				pre_x = -y_in;
				pre_y = x_in;
				pre_z = -tccb_pkg::ANG_QUARTER;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= pre_x;
			y_q[0]    <= pre_y;
			z_q[0]    <= pre_z;
			zero_q[0] <= (x_in == '0) && (y_in == '0);
			for (int i = 0; i < N; i++) begin
				zero_q[i+1] <= zero_q[i];
				if (!y_q[i][W-1]) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + tccb_pkg::ATAN_TAB[i];
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - tccb_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	assign z_out = zero_q[N] ? '0 : z_q[N];

endmodule

>>> sv/tccb_rot_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_rot_cordic
// Pipelined rotation CORDIC: Q15 cosine and sine of a 16-bit binary angle.
// ----------------------------------------------------------------------------
module tccb_rot_cordic #(
	parameter int N = tccb_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [16:0] ang,
	output logic signed [16:0] cos_out,
	output logic signed [16:0] sin_out
);

	localparam int ZW = tccb_pkg::ZW;

	logic signed [ZW-1:0] x_q [0:N];
	logic signed [ZW-1:0] y_q [0:N];
	logic signed [ZW-1:0] z_q [0:N];
	logic                 neg_q [0:N];
	logic signed [16:0]   cos_q;
	logic signed [16:0]   sin_q;

	logic signed [ZW-1:0] za;
	logic signed [ZW-1:0] zr;
	logic                 zneg;
	logic signed [ZW-1:0] xr;
	logic signed [ZW-1:0] yr;
	logic signed [16:0]   xc;
	logic signed [16:0]   ys;

	assign za = {ang[16], ang, 16'h0000};

	// fold angles beyond a quarter turn, negate at the end
	always_comb begin
		zr   = za;
		zneg = 1'b0;
		if (za > tccb_pkg::ANG_QUARTER) begin
			zr   = za - (tccb_pkg::ANG_QUARTER <<< 1);
			zneg = 1'b1;
		end else if (za < -tccb_pkg::ANG_QUARTER) begin
			zr   = za + (tccb_pkg::ANG_QUARTER <<< 1);
			zneg = 1'b1;
		end
	end

	assign xr = (x_q[N] + 34'sd16384) >>> 15;
	assign yr = (y_q[N] + 34'sd16384) >>> 15;
	assign xc = xr[16:0];
	assign ys = yr[16:0];

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]   <= tccb_pkg::INV_GAIN_Q30;
			y_q[0]   <= '0;
			z_q[0]   <= zr;
			neg_q[0] <= zneg;
			for (int i = 0; i < N; i++) begin
				neg_q[i+1] <= neg_q[i];
				if (!z_q[i][ZW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - tccb_pkg::ATAN_TAB[i];
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + tccb_pkg::ATAN_TAB[i];
				end
			end
			cos_q <= neg_q[N] ? -xc : xc;
			sin_q <= neg_q[N] ? -ys : ys;
		end
	end

	assign cos_out = cos_q;
	assign sin_out = sin_q;

endmodule

>>> sv/tilt_compensated_compass_bearing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_compass_bearing
// Tilt-compensated compass bearing from one accelerometer and one
// magnetometer sample, with gravity, tilt and horizontal field checks.
//
//   channel   role   handshake     payload
//   sample    in     valid/ready   accel_x/y/z, field_x/y/z
//   result    out    valid/ready   heading, status
//   cfg       in     cfg_we        cfg_idx, cfg_data
//
// One transaction per cycle while no result waits untaken, through three chained
// CORDIC pipelines.
// Reset clears all valid bits and loads the register defaults.
// When a result waits untaken the whole pipeline holds and sample.ready drops.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_bearing #(
	parameter int CORDIC_ITERATIONS = tccb_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tccb_pkg::CFG_AW-1:0]   cfg_idx,
	input  logic [tccb_pkg::CFG_DW-1:0]   cfg_data,
	tccb_sample_if.sink                   sample,
	tccb_result_if.source                 result
);

	localparam int N      = CORDIC_ITERATIONS;
	localparam int ZW     = tccb_pkg::ZW;
	localparam int VW     = 36;
	localparam int PW     = 48;
	localparam int HW     = 52;
	localparam int P_TILT = N + 5;
	localparam int P_FLD  = 2 * N + 5;
	localparam int P_WEAK = 2 * N + 9;
	localparam int P_HEAD = 3 * N + 9;
	localparam int L      = 3 * N + 10;

	logic [31:0] mag_min_q;
	logic [31:0] mag_max_q;
	logic [31:0] tilt_lim_q;
	logic [15:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_min_q  <= 32'd67108864;
			mag_max_q  <= 32'd150994944;
			tilt_lim_q <= 32'd29822521;
			eps_q      <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				tccb_pkg::CFG_MAG_MIN:   mag_min_q  <= cfg_data;
				tccb_pkg::CFG_MAG_MAX:   mag_max_q  <= cfg_data;
				tccb_pkg::CFG_TILT_LIM:  tilt_lim_q <= cfg_data;
				tccb_pkg::CFG_FIELD_EPS: eps_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic vld_q [1:L];
	tccb_pkg::status_t st_q [2:L];
	tccb_pkg::status_t st_nx [2:L];

	assign en = !vld_q[L] || result.ready;
	assign sample.ready = en;

	// stage 1: capture and square the acceleration
	logic signed [15:0] ax_s1, ay_s1, az_s1;
	logic signed [15:0] fx_s1, fy_s1, fz_s1;
	logic [30:0]        ax2_s1, ay2_s1, az2_s1;
	logic signed [31:0] ax2_w, ay2_w, az2_w;

	assign ax2_w = sample.accel_x * sample.accel_x;
	assign ay2_w = sample.accel_y * sample.accel_y;
	assign az2_w = sample.accel_z * sample.accel_z;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= sample.accel_x;
			ay_s1  <= sample.accel_y;
			az_s1  <= sample.accel_z;
			fx_s1  <= sample.field_x;
			fy_s1  <= sample.field_y;
			fz_s1  <= sample.field_z;
			ax2_s1 <= ax2_w[30:0];
			ay2_s1 <= ay2_w[30:0];
			az2_s1 <= az2_w[30:0];
		end
	end

	logic [31:0] magsq;
	logic        grav_bad;
	assign magsq = 32'(ax2_s1) + 32'(ay2_s1) + 32'(az2_s1);
	assign grav_bad = (magsq < mag_min_q) || (magsq > mag_max_q);

	// pitch and roll
	logic signed [VW-1:0] ax_v, ay_v, az_v;
	logic signed [ZW-1:0] pz, rz;
	assign ax_v = {{4{ax_s1[15]}}, ax_s1, 16'h0000};
	assign ay_v = {{4{ay_s1[15]}}, ay_s1, 16'h0000};
	assign az_v = {{4{az_s1[15]}}, az_s1, 16'h0000};

	tccb_vec_cordic #(.W(VW), .N(N)) u_pitch (
		.clk(clk), .en(en), .x_in(-az_v), .y_in(ax_v), .z_out(pz)
	);
	tccb_vec_cordic #(.W(VW), .N(N)) u_roll (
		.clk(clk), .en(en), .x_in(-az_v), .y_in(-ay_v), .z_out(rz)
	);

	logic signed [ZW-1:0] pz_r, rz_r;
	logic signed [16:0]   pitch_s2, roll_s2;
	logic signed [33:0]   p2_w, r2_w;
	logic [31:0]          p2_s3, r2_s3;
	logic [31:0]          tilt_sum;

	assign pz_r = (pz + 34'sd32768) >>> 16;
	assign rz_r = (rz + 34'sd32768) >>> 16;
	assign p2_w = pitch_s2 * pitch_s2;
	assign r2_w = roll_s2 * roll_s2;
	assign tilt_sum = p2_s3 + r2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_s2 <= pz_r[16:0];
			roll_s2  <= rz_r[16:0];
			p2_s3    <= p2_w[31:0];
			r2_s3    <= r2_w[31:0];
		end
	end

	// sine and cosine of pitch and roll
	logic signed [16:0] cp, sp, cr, sr;

	tccb_rot_cordic #(.N(N)) u_rot_pitch (
		.clk(clk), .en(en), .ang(pitch_s2), .cos_out(cp), .sin_out(sp)
	);
	tccb_rot_cordic #(.N(N)) u_rot_roll (
		.clk(clk), .en(en), .ang(roll_s2), .cos_out(cr), .sin_out(sr)
	);

	// field delay up to the projection
	logic signed [15:0] fx_line_q [2:P_FLD];
	logic signed [15:0] fy_line_q [2:P_FLD];
	logic signed [15:0] fz_line_q [2:P_FLD];

	always_ff @(posedge clk) begin
		if (en) begin
			fx_line_q[2] <= fx_s1;
			fy_line_q[2] <= fy_s1;
			fz_line_q[2] <= fz_s1;
			for (int p = 3; p <= P_FLD; p++) begin
				fx_line_q[p] <= fx_line_q[p-1];
				fy_line_q[p] <= fy_line_q[p-1];
				fz_line_q[p] <= fz_line_q[p-1];
			end
		end
	end

	// horizontal projection
	logic signed [32:0] fxcp_s4, fysr_s4, fzcr_s4, fycr_s4, fzsr_s4;
	logic signed [16:0] sp_s4, sp_s5;
	logic signed [33:0] d_s5, ysum_s5;
	logic signed [32:0] xcp_s5;
	logic signed [PW-1:0] px_s6, py_s6;
	logic signed [50:0] xcp_w, dsp_w, px_w;

	assign xcp_w = 51'(xcp_s5) <<< 15;
	assign dsp_w = d_s5 * sp_s5;
	assign px_w  = xcp_w + dsp_w;

	always_ff @(posedge clk) begin
		if (en) begin
			fxcp_s4 <= fx_line_q[P_FLD] * cp;
			fysr_s4 <= fy_line_q[P_FLD] * sr;
			fzcr_s4 <= fz_line_q[P_FLD] * cr;
			fycr_s4 <= fy_line_q[P_FLD] * cr;
			fzsr_s4 <= fz_line_q[P_FLD] * sr;
			sp_s4   <= sp;
			d_s5    <= 34'(fysr_s4) - 34'(fzcr_s4);
			ysum_s5 <= 34'(fycr_s4) + 34'(fzsr_s4);
			xcp_s5  <= fxcp_s4;
			sp_s5   <= sp_s4;
			px_s6   <= px_w[PW-1:0];
			py_s6   <= 48'(ysum_s5) <<< 15;
		end
	end

	logic [PW-1:0] px_abs, py_abs, lim;
	logic          field_weak;
	assign px_abs     = px_s6[PW-1] ? -px_s6 : px_s6;
	assign py_abs     = py_s6[PW-1] ? -py_s6 : py_s6;
	assign lim        = {2'b00, eps_q, 30'h0};
	assign field_weak = (px_abs < lim) && (py_abs < lim);

	// bearing
	logic signed [ZW-1:0] hz, hz_r;
	logic signed [15:0]   heading_s7;

	tccb_vec_cordic #(.W(HW), .N(N)) u_head (
		.clk(clk), .en(en),
		.x_in({{(HW-PW){px_s6[PW-1]}}, px_s6}),
		.y_in({{(HW-PW){py_s6[PW-1]}}, py_s6}),
		.z_out(hz)
	);

	assign hz_r = (34'sd32768 - hz) >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			heading_s7 <= (st_q[P_HEAD] == tccb_pkg::ST_OK) ? hz_r[15:0] : 16'sd0;
		end
	end

	// status and valid travel with the item
	always_comb begin
		st_nx[2] = grav_bad ? tccb_pkg::ST_GRAVITY : tccb_pkg::ST_OK;
		for (int p = 3; p <= L; p++) begin
			st_nx[p] = st_q[p-1];
			if (p == P_TILT && st_q[p-1] == tccb_pkg::ST_OK && tilt_sum >= tilt_lim_q)
				st_nx[p] = tccb_pkg::ST_TILT;
			if (p == P_WEAK && st_q[p-1] == tccb_pkg::ST_OK && field_weak)
				st_nx[p] = tccb_pkg::ST_FIELD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 1; p <= L; p++) vld_q[p] <= 1'b0;
			for (int p = 2; p <= L; p++) st_q[p] <= tccb_pkg::ST_OK;
		end else if (en) begin
			vld_q[1] <= sample.valid;
			for (int p = 2; p <= L; p++) begin
				vld_q[p] <= vld_q[p-1];
				st_q[p]  <= st_nx[p];
			end
		end
	end

	assign result.valid   = vld_q[L];
	assign result.heading = heading_s7;
	assign result.status  = st_q[L];

endmodule

>>> sv/tccb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccb_checker
// Port-level checks of the compass bearing block, bound to the top level.
// ----------------------------------------------------------------------------
module tccb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] heading,
	input logic [1:0]         status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(heading) && $stable(status))
		else $error("result changed while stalled");

	a_zero_heading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tccb_pkg::ST_OK |-> heading == 16'sd0)
		else $error("rejected sample carries a heading");

	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_reset_clear: assert property (@(posedge clk)
		$past(!arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind tilt_compensated_compass_bearing tccb_checker u_tccb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(sample.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.heading(result.heading),
	.status(result.status)
);
